// ===== hdl/fpf_pkg.sv =====
package fpf_pkg;

   localparam int FRAME_COUNT      = 100;
   localparam int SUBFRAME_COUNT   = 10;
   localparam int SLOT_COUNT       = 8;
   localparam int SYMBOLS_PER_SLOT = 14;
   localparam int BYTES_PER_RB     = 48;
   localparam int HEADER_BYTES     = 8;
   localparam int SAMPLE_BYTES     = 4;

   localparam int BYTE_W      = 8;
   localparam int SAMPLE_W    = 16;
   localparam int PPS_W       = 9;
   localparam int SPS_W       = 7;
   localparam int RBS_W       = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam int FRAME_ID_W    = $clog2(FRAME_COUNT);
   localparam int SUBFRAME_ID_W = $clog2(SUBFRAME_COUNT);
   localparam int SLOT_ID_W     = $clog2(SLOT_COUNT);
   localparam int SYMBOL_ID_W   = $clog2(SYMBOLS_PER_SLOT);

   // period widths follow from the largest register values
   localparam int PPS_MAX        = 2 ** PPS_W - 1;
   localparam int SPS_MAX        = 2 ** SPS_W - 1;
   localparam int RBS_MAX        = 2 ** RBS_W - 1;
   localparam int SLOT_PERIOD_W  = $clog2(PPS_MAX * SYMBOLS_PER_SLOT + 1);
   localparam int SUB_PERIOD_W   = $clog2(PPS_MAX * SYMBOLS_PER_SLOT * SPS_MAX + 1);
   localparam int FRAME_PERIOD_W =
      $clog2(PPS_MAX * SYMBOLS_PER_SLOT * SPS_MAX * SUBFRAME_COUNT + 1);

   localparam int RB_BYTES_W = $clog2(RBS_MAX * BYTES_PER_RB + 1);
   localparam int SPP_MAX    =
      (RBS_MAX * BYTES_PER_RB - HEADER_BYTES + SAMPLE_BYTES - 1) / SAMPLE_BYTES;
   localparam int SPP_W      = $clog2(SPP_MAX + 1);

   localparam int SETTLE_CYCLES = 3;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PACKETS_PER_SYMBOL = 3'd0,
      CSR_SLOTS_PER_SUBFRAME = 3'd1,
      CSR_RBS_PER_PACKET     = 3'd2,
      CSR_FIRST_BYTE         = 3'd3,
      CSR_SECTION_ID         = 3'd4,
      CSR_SYMBOL_INCREMENT   = 3'd5,
      CSR_START_PRB          = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      BYTE_FIRST     = 4'd0,
      BYTE_FRAME     = 4'd1,
      BYTE_SUB_SLOT  = 4'd2,
      BYTE_SYMBOL    = 4'd3,
      BYTE_SECTION   = 4'd4,
      BYTE_SYM_INC   = 4'd5,
      BYTE_START_PRB = 4'd6,
      BYTE_RBS       = 4'd7,
      BYTE_RE_LO     = 4'd8,
      BYTE_RE_HI     = 4'd9,
      BYTE_IM_LO     = 4'd10,
      BYTE_IM_HI     = 4'd11
   } byte_sel_type;

   typedef struct packed {
      logic [FRAME_ID_W-1:0]    frame_id;
      logic [SUBFRAME_ID_W-1:0] subframe_id;
      logic [SLOT_ID_W-1:0]     slot_id;
      logic [SYMBOL_ID_W-1:0]   symbol_id;
      logic [SAMPLE_W-1:0]      sample_real;
      logic [SAMPLE_W-1:0]      sample_imag;
      logic                     packet_end;
   } item_type;

endpackage

// ===== hdl/fpf_req_if.sv =====
interface fpf_req_if;
   logic                                         valid;
   logic                                         ready;
   logic signed [fpf_pkg::SAMPLE_W-1:0]          sample_real;
   logic signed [fpf_pkg::SAMPLE_W-1:0]          sample_imag;

   modport source (output valid, output sample_real, output sample_imag, input ready);
   modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

// ===== hdl/fpf_rsp_if.sv =====
interface fpf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fpf_pkg::BYTE_W-1:0]  out_byte;
   logic                        packet_end;
   logic                        run_end;

   modport source (output valid, output out_byte, output packet_end, output run_end,
                   input ready);
   modport sink   (input valid, input out_byte, input packet_end, input run_end,
                   output ready);
endinterface

// ===== hdl/fronthaul_packet_framer_unit.sv =====
// Fronthaul packet framer.
// req_bus carries one I/Q sample per request; rsp_bus carries one byte per
// request. A sample that opens a packet yields the 8 header bytes and then
// its 4 sample bytes, any other sample yields its 4 bytes. packet_end marks
// the last byte of a packet, run_end the last byte of each sample.
// The first byte of a sample reaches rsp_bus through the serialiser register
// and then the output register. Throughput is set by the byte-wide output,
// which sends each header and sample byte in turn. One sample is held in
// the serialiser; the next is accepted in the cycle its last byte moves to
// the output register, so samples stream without gaps.
// The csr_ port writes registers directly; the derived packet periods
// and payload length are registered products, and req_bus.ready is low
// while they settle after a write. The same settling follows reset.
// Reset restores the register defaults, clears the ids, period counters
// and packet position, and empties the output.
// A stall on rsp_bus holds the output byte; the serialiser and then
// req_bus.ready wait behind it, nothing is dropped.
module fronthaul_packet_framer_unit (
   input  logic                              clock,
   input  logic                              reset,
   fpf_req_if.sink                           req_bus,
   fpf_rsp_if.source                         rsp_bus,
   input  logic                              csr_write_en,
   input  logic [fpf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fpf_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // configuration
   logic [fpf_pkg::PPS_W-1:0]  pps_ff;
   logic [fpf_pkg::SPS_W-1:0]  sps_ff;
   logic [fpf_pkg::RBS_W-1:0]  rbs_ff;
   logic [fpf_pkg::BYTE_W-1:0] first_byte_ff;
   logic [fpf_pkg::BYTE_W-1:0] section_id_ff;
   logic [fpf_pkg::BYTE_W-1:0] symbol_inc_ff;
   logic [fpf_pkg::BYTE_W-1:0] start_prb_ff;

   // derived from configuration
   logic [fpf_pkg::PPS_W-1:0]          pps_fix;
   logic [fpf_pkg::SPS_W-1:0]          sps_fix;
   logic [fpf_pkg::PPS_W-1:0]          sym_period_ff;
   logic [fpf_pkg::SPS_W-1:0]          sps_eff_ff;
   logic [fpf_pkg::SLOT_PERIOD_W-1:0]  slot_period_ff;
   logic [fpf_pkg::SUB_PERIOD_W-1:0]   sub_period_ff;
   logic [fpf_pkg::FRAME_PERIOD_W-1:0] frame_period_ff;
   logic [fpf_pkg::RB_BYTES_W-1:0]     rb_bytes;
   logic [fpf_pkg::SPP_W-1:0]          spp_in;
   logic [fpf_pkg::SPP_W-1:0]          spp_ff;
   logic [fpf_pkg::SETTLE_W-1:0]       settle_ff;

   // framing state
   logic [fpf_pkg::FRAME_ID_W-1:0]     frame_id_ff, frame_id_in;
   logic [fpf_pkg::SUBFRAME_ID_W-1:0]  subframe_id_ff, subframe_id_in;
   logic [fpf_pkg::SLOT_ID_W-1:0]      slot_id_ff, slot_id_in;
   logic [fpf_pkg::SYMBOL_ID_W-1:0]    symbol_id_ff, symbol_id_in;
   logic [fpf_pkg::SPP_W-1:0]          sip_ff, sip_in, sip_next;
   logic [fpf_pkg::PPS_W-1:0]          cnt_sym_ff, cnt_sym_in, cnt_sym_next;
   logic [fpf_pkg::SLOT_PERIOD_W-1:0]  cnt_slot_ff, cnt_slot_in, cnt_slot_next;
   logic [fpf_pkg::SUB_PERIOD_W-1:0]   cnt_sub_ff, cnt_sub_in, cnt_sub_next;
   logic [fpf_pkg::FRAME_PERIOD_W-1:0] cnt_frame_ff, cnt_frame_in, cnt_frame_next;
   logic                               tick_sym, tick_slot, tick_sub, tick_frame;
   logic                               opens_packet, pend;

   // serialiser and output register
   logic                         cur_valid_ff;
   fpf_pkg::item_type            cur_ff, item_in;
   fpf_pkg::byte_sel_type        idx_ff;
   logic                         out_load, cur_last, cur_done, req_fire;
   logic [fpf_pkg::BYTE_W-1:0]   byte_sel;
   logic                         rsp_valid_ff;
   logic [fpf_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic                         rsp_pend_ff;
   logic                         rsp_run_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff        <= fpf_pkg::PPS_W'(1);
         sps_ff        <= fpf_pkg::SPS_W'(1);
         rbs_ff        <= fpf_pkg::RBS_W'(1);
         first_byte_ff <= '0;
         section_id_ff <= '0;
         symbol_inc_ff <= '0;
         start_prb_ff  <= '0;
      end else if (csr_write_en) begin
         case (fpf_pkg::csr_index_type'(csr_index))
            fpf_pkg::CSR_PACKETS_PER_SYMBOL: pps_ff <= csr_write_data[fpf_pkg::PPS_W-1:0];
            fpf_pkg::CSR_SLOTS_PER_SUBFRAME: sps_ff <= csr_write_data[fpf_pkg::SPS_W-1:0];
            fpf_pkg::CSR_RBS_PER_PACKET:     rbs_ff <= csr_write_data[fpf_pkg::RBS_W-1:0];
            fpf_pkg::CSR_FIRST_BYTE: first_byte_ff <= csr_write_data[fpf_pkg::BYTE_W-1:0];
            fpf_pkg::CSR_SECTION_ID: section_id_ff <= csr_write_data[fpf_pkg::BYTE_W-1:0];
            fpf_pkg::CSR_SYMBOL_INCREMENT:
               symbol_inc_ff <= csr_write_data[fpf_pkg::BYTE_W-1:0];
            fpf_pkg::CSR_START_PRB:  start_prb_ff  <= csr_write_data[fpf_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // zero counts act as one
   assign pps_fix  = (pps_ff == '0) ? fpf_pkg::PPS_W'(1) : pps_ff;
   assign sps_fix  = (sps_ff == '0) ? fpf_pkg::SPS_W'(1) : sps_ff;
   assign rb_bytes = fpf_pkg::RB_BYTES_W'(rbs_ff) *
                     fpf_pkg::RB_BYTES_W'(fpf_pkg::BYTES_PER_RB);

   always_comb begin
      if (rb_bytes <= fpf_pkg::RB_BYTES_W'(fpf_pkg::HEADER_BYTES)) begin
         spp_in = fpf_pkg::SPP_W'(1);
      end else begin
         spp_in = fpf_pkg::SPP_W'((rb_bytes - fpf_pkg::RB_BYTES_W'(fpf_pkg::HEADER_BYTES)
                  + fpf_pkg::RB_BYTES_W'(fpf_pkg::SAMPLE_BYTES - 1))
                  / fpf_pkg::SAMPLE_BYTES);
      end
   end

   // one multiplication per stage; the settle count covers the chain
   always_ff @(posedge clock) begin
      sym_period_ff   <= pps_fix;
      sps_eff_ff      <= sps_fix;
      slot_period_ff  <= fpf_pkg::SLOT_PERIOD_W'(pps_fix) *
                         fpf_pkg::SLOT_PERIOD_W'(fpf_pkg::SYMBOLS_PER_SLOT);
      sub_period_ff   <= fpf_pkg::SUB_PERIOD_W'(slot_period_ff) *
                         fpf_pkg::SUB_PERIOD_W'(sps_eff_ff);
      frame_period_ff <= fpf_pkg::FRAME_PERIOD_W'(sub_period_ff) *
                         fpf_pkg::FRAME_PERIOD_W'(fpf_pkg::SUBFRAME_COUNT);
      spp_ff          <= spp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         settle_ff <= fpf_pkg::SETTLE_W'(fpf_pkg::SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - fpf_pkg::SETTLE_W'(1);
      end
   end

   // ---------------- handshake ----------------
   assign out_load      = !rsp_valid_ff || rsp_bus.ready;
   assign cur_last      = (idx_ff == fpf_pkg::BYTE_IM_HI);
   assign cur_done      = cur_valid_ff && out_load && cur_last;
   assign req_bus.ready = (settle_ff == '0) && (!cur_valid_ff || cur_done);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // ---------------- framing state ----------------
   always_comb begin
      opens_packet   = (sip_ff == '0);
      cnt_sym_next   = cnt_sym_ff + fpf_pkg::PPS_W'(1);
      cnt_slot_next  = cnt_slot_ff + fpf_pkg::SLOT_PERIOD_W'(1);
      cnt_sub_next   = cnt_sub_ff + fpf_pkg::SUB_PERIOD_W'(1);
      cnt_frame_next = cnt_frame_ff + fpf_pkg::FRAME_PERIOD_W'(1);
      // >= rather than == since a shortened period may leave a counter above it
      tick_sym   = (cnt_sym_next >= sym_period_ff);
      tick_slot  = (cnt_slot_next >= slot_period_ff);
      tick_sub   = (cnt_sub_next >= sub_period_ff);
      tick_frame = (cnt_frame_next >= frame_period_ff);
      sip_next   = sip_ff + fpf_pkg::SPP_W'(1);
      pend       = (sip_next >= spp_ff);

      frame_id_in    = frame_id_ff;
      subframe_id_in = subframe_id_ff;
      slot_id_in     = slot_id_ff;
      symbol_id_in   = symbol_id_ff;
      cnt_sym_in     = cnt_sym_ff;
      cnt_slot_in    = cnt_slot_ff;
      cnt_sub_in     = cnt_sub_ff;
      cnt_frame_in   = cnt_frame_ff;
      sip_in         = sip_ff;

      if (req_fire) begin
         sip_in = pend ? '0 : sip_next;
         if (opens_packet) begin
            cnt_sym_in   = tick_sym   ? '0 : cnt_sym_next;
            cnt_slot_in  = tick_slot  ? '0 : cnt_slot_next;
            cnt_sub_in   = tick_sub   ? '0 : cnt_sub_next;
            cnt_frame_in = tick_frame ? '0 : cnt_frame_next;
            if (tick_frame) begin
               frame_id_in = (frame_id_ff == fpf_pkg::FRAME_ID_W'(fpf_pkg::FRAME_COUNT - 1))
                             ? '0 : frame_id_ff + fpf_pkg::FRAME_ID_W'(1);
            end
            if (tick_sub) begin
               subframe_id_in =
                  (subframe_id_ff == fpf_pkg::SUBFRAME_ID_W'(fpf_pkg::SUBFRAME_COUNT - 1))
                  ? '0 : subframe_id_ff + fpf_pkg::SUBFRAME_ID_W'(1);
            end
            if (tick_slot) begin
               slot_id_in = (slot_id_ff == fpf_pkg::SLOT_ID_W'(fpf_pkg::SLOT_COUNT - 1))
                            ? '0 : slot_id_ff + fpf_pkg::SLOT_ID_W'(1);
            end
            if (tick_sym) begin
               symbol_id_in =
                  (symbol_id_ff == fpf_pkg::SYMBOL_ID_W'(fpf_pkg::SYMBOLS_PER_SLOT - 1))
                  ? '0 : symbol_id_ff + fpf_pkg::SYMBOL_ID_W'(1);
            end
         end
      end

      // header carries the ids as they were before this packet's advance
      item_in.frame_id    = frame_id_ff;
      item_in.subframe_id = subframe_id_ff;
      item_in.slot_id     = slot_id_ff;
      item_in.symbol_id   = symbol_id_ff;
      item_in.sample_real = req_bus.sample_real;
      item_in.sample_imag = req_bus.sample_imag;
      item_in.packet_end  = pend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff    <= '0;
         subframe_id_ff <= '0;
         slot_id_ff     <= '0;
         symbol_id_ff   <= '0;
         sip_ff         <= '0;
         cnt_sym_ff     <= '0;
         cnt_slot_ff    <= '0;
         cnt_sub_ff     <= '0;
         cnt_frame_ff   <= '0;
      end else begin
         frame_id_ff    <= frame_id_in;
         subframe_id_ff <= subframe_id_in;
         slot_id_ff     <= slot_id_in;
         symbol_id_ff   <= symbol_id_in;
         sip_ff         <= sip_in;
         cnt_sym_ff     <= cnt_sym_in;
         cnt_slot_ff    <= cnt_slot_in;
         cnt_sub_ff     <= cnt_sub_in;
         cnt_frame_ff   <= cnt_frame_in;
      end
   end

   // ---------------- serialiser ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= fpf_pkg::BYTE_FIRST;
      end else if (req_fire) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= opens_packet ? fpf_pkg::BYTE_FIRST : fpf_pkg::BYTE_RE_LO;
      end else if (cur_done) begin
         cur_valid_ff <= 1'b0;
      end else if (cur_valid_ff && out_load) begin
         idx_ff <= fpf_pkg::byte_sel_type'(idx_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff <= item_in;
      end
   end

   always_comb begin
      case (idx_ff)
         fpf_pkg::BYTE_FIRST:     byte_sel = first_byte_ff;
         fpf_pkg::BYTE_FRAME:     byte_sel = fpf_pkg::BYTE_W'(cur_ff.frame_id);
         fpf_pkg::BYTE_SUB_SLOT:
            byte_sel = (fpf_pkg::BYTE_W'(cur_ff.subframe_id) << 4) |
                       fpf_pkg::BYTE_W'(cur_ff.slot_id);
         fpf_pkg::BYTE_SYMBOL:    byte_sel = fpf_pkg::BYTE_W'(cur_ff.symbol_id);
         fpf_pkg::BYTE_SECTION:   byte_sel = section_id_ff;
         fpf_pkg::BYTE_SYM_INC:   byte_sel = symbol_inc_ff;
         fpf_pkg::BYTE_START_PRB: byte_sel = start_prb_ff;
         fpf_pkg::BYTE_RBS:       byte_sel = rbs_ff;
         fpf_pkg::BYTE_RE_LO:     byte_sel = cur_ff.sample_real[7:0];
         fpf_pkg::BYTE_RE_HI:     byte_sel = cur_ff.sample_real[15:8];
         fpf_pkg::BYTE_IM_LO:     byte_sel = cur_ff.sample_imag[7:0];
         fpf_pkg::BYTE_IM_HI:     byte_sel = cur_ff.sample_imag[15:8];
         default:                 byte_sel = '0;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cur_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && cur_valid_ff) begin
         rsp_byte_ff <= byte_sel;
         rsp_pend_ff <= cur_last && cur_ff.packet_end;
         rsp_run_ff  <= cur_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_byte   = rsp_byte_ff;
   assign rsp_bus.packet_end = rsp_pend_ff;
   assign rsp_bus.run_end    = rsp_run_ff;

   // ---------------- assertions ----------------
   a_settle_blocks: assert property (@(posedge clock) disable iff (reset)
      (settle_ff != '0) |-> !req_bus.ready)
      else $error("request accepted while derived periods settle");

   a_pend_on_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pend_ff) |-> rsp_run_ff)
      else $error("packet end away from the last byte of a sample");

   a_header_first: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (sip_ff == '0)) |=> (cur_valid_ff && idx_ff == fpf_pkg::BYTE_FIRST))
      else $error("packet opened without header");

   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (sip_ff != '0)) |=> (cur_valid_ff && idx_ff == fpf_pkg::BYTE_RE_LO))
      else $error("mid-packet sample does not start at its payload bytes");

endmodule

// ===== verif/tb_fronthaul_packet_framer_unit.sv =====
`timescale 1ns / 100ps

module tb_fronthaul_packet_framer_unit;
   import fpf_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int RANDOM_ITEMS     = 410;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES      = 20;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_end;
      logic              run_end;
   } stream_byte_type;

   // Predicts the byte stream of the framer and checks the bytes that come out.
   class byte_stream_scoreboard;
      logic [PPS_W-1:0]  pkts_per_symbol;
      logic [SPS_W-1:0]  slots_per_sub;
      logic [RBS_W-1:0]  rbs_per_pkt;
      logic [BYTE_W-1:0] first_hdr_byte;
      logic [BYTE_W-1:0] section_byte;
      logic [BYTE_W-1:0] sym_inc_byte;
      logic [BYTE_W-1:0] start_prb_byte;

      int unsigned frame_id;
      int unsigned subframe_id;
      int unsigned slot_id;
      int unsigned symbol_id;
      int unsigned samples_done;
      int unsigned period_count[4];

      stream_byte_type expected_bytes[$];
      int unsigned     mismatches;

      function new();
         pkts_per_symbol = PPS_W'(1);
         slots_per_sub   = SPS_W'(1);
         rbs_per_pkt     = RBS_W'(1);
         first_hdr_byte  = '0;
         section_byte    = '0;
         sym_inc_byte    = '0;
         start_prb_byte  = '0;
         frame_id        = 0;
         subframe_id     = 0;
         slot_id         = 0;
         symbol_id       = 0;
         samples_done    = 0;
         foreach (period_count[i]) period_count[i] = 0;
         mismatches      = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PACKETS_PER_SYMBOL: pkts_per_symbol = data[PPS_W-1:0];
            CSR_SLOTS_PER_SUBFRAME: slots_per_sub   = data[SPS_W-1:0];
            CSR_RBS_PER_PACKET:     rbs_per_pkt     = data[RBS_W-1:0];
            CSR_FIRST_BYTE:         first_hdr_byte  = data[BYTE_W-1:0];
            CSR_SECTION_ID:         section_byte    = data[BYTE_W-1:0];
            CSR_SYMBOL_INCREMENT:   sym_inc_byte    = data[BYTE_W-1:0];
            CSR_START_PRB:          start_prb_byte  = data[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function bit tick_period(int which, int unsigned period);
         int unsigned nxt;
         nxt = period_count[which] + 1;
         if (nxt >= period) begin
            period_count[which] = 0;
            return 1'b1;
         end
         period_count[which] = nxt;
         return 1'b0;
      endfunction

      function int unsigned advance_id(int unsigned id, bit advance, int unsigned count);
         int unsigned n;
         n = advance ? id + 1 : id;
         return (n >= count) ? 0 : n;
      endfunction

      function void push_byte(logic [BYTE_W-1:0] b, logic pe, logic last);
         stream_byte_type e;
         e.out_byte   = b;
         e.packet_end = pe;
         e.run_end    = last;
         expected_bytes = {expected_bytes, e};
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] re_bits, logic [SAMPLE_W-1:0] im_bits);
         int unsigned payload_bytes, total, pps, sps, slot_p, sub_p, frame_p;
         bit          f, sl, sf, sy;
         logic        pend;
         logic [7:0]  sub_slot;
         payload_bytes = rbs_per_pkt * BYTES_PER_RB;
         if (payload_bytes <= HEADER_BYTES) total = 1;
         else total = (payload_bytes - HEADER_BYTES + SAMPLE_BYTES - 1) / SAMPLE_BYTES;
         if (total == 0) total = 1;
         pps     = (pkts_per_symbol == 0) ? 1 : pkts_per_symbol;
         sps     = (slots_per_sub == 0) ? 1 : slots_per_sub;
         slot_p  = pps * SYMBOLS_PER_SLOT;
         sub_p   = slot_p * sps;
         frame_p = sub_p * SUBFRAME_COUNT;

         if (samples_done == 0) begin
            sub_slot = 8'((subframe_id << 4) | slot_id);
            push_byte(first_hdr_byte, 1'b0, 1'b0);
            push_byte(8'(frame_id), 1'b0, 1'b0);
            push_byte(sub_slot, 1'b0, 1'b0);
            push_byte(8'(symbol_id), 1'b0, 1'b0);
            push_byte(section_byte, 1'b0, 1'b0);
            push_byte(sym_inc_byte, 1'b0, 1'b0);
            push_byte(start_prb_byte, 1'b0, 1'b0);
            push_byte(rbs_per_pkt, 1'b0, 1'b0);
            // ids step after the header that carries them
            f  = tick_period(3, frame_p);
            sl = tick_period(1, slot_p);
            sf = tick_period(2, sub_p);
            sy = tick_period(0, pps);
            frame_id    = advance_id(frame_id, f, FRAME_COUNT);
            slot_id     = advance_id(slot_id, sl, SLOT_COUNT);
            subframe_id = advance_id(subframe_id, sf, SUBFRAME_COUNT);
            symbol_id   = advance_id(symbol_id, sy, SYMBOLS_PER_SLOT);
         end

         samples_done++;
         pend = 1'b0;
         if (samples_done >= total) begin
            samples_done = 0;
            pend = 1'b1;
         end
         push_byte(re_bits[7:0], 1'b0, 1'b0);
         push_byte(re_bits[15:8], 1'b0, 1'b0);
         push_byte(im_bits[7:0], 1'b0, 1'b0);
         push_byte(im_bits[15:8], pend, 1'b1);
      endfunction

      function void check_byte(stream_byte_type got);
         stream_byte_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected byte %h packet_end %b run_end %b",
                        $realtime, got.out_byte, got.packet_end, got.run_end);
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.packet_end !== want.packet_end ||
             got.run_end !== want.run_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: byte mismatch exp %h/%b/%b got %h/%b/%b", $realtime,
                        want.out_byte, want.packet_end, want.run_end,
                        got.out_byte, got.packet_end, got.run_end);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   fpf_req_if req_bus ();
   fpf_rsp_if rsp_bus ();

   byte_stream_scoreboard sb = new();

   int unsigned holds_asked = 0;

   fronthaul_packet_framer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // periods and payload size kept small most of the time
   function automatic logic [CSR_DATA_W-1:0] pick_setting();
      if ($urandom_range(0, 9) < 7) return CSR_DATA_W'($urandom_range(0, 3));
      return CSR_DATA_W'($urandom_range(0, 2 ** CSR_DATA_W - 1));
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                              input logic signed [SAMPLE_W-1:0] im,
                              input int unsigned gap);
      req_bus.valid       <= 1'b1;
      req_bus.sample_real <= re;
      req_bus.sample_imag <= im;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_sample(re, im);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // response side: checks every byte, idles at random, honours long hold requests
   initial begin
      int unsigned     hold_left;
      int unsigned     gap_left;
      int unsigned     holds_done;
      int unsigned     window;
      bit              calm;
      stream_byte_type got;
      hold_left  = 0;
      gap_left   = 0;
      holds_done = 0;
      window     = 0;
      calm       = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.out_byte   = rsp_bus.out_byte;
            got.packet_end = rsp_bus.packet_end;
            got.run_end    = rsp_bus.run_end;
            sb.check_byte(got);
         end
         window++;
         if (window >= 100) begin
            window = 0;
            calm   = ($urandom_range(0, 2) == 0);
         end
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) gap_left = pick_gap(calm);
         end
      end
   end

   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned phase_len;
      bit          calm;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.sample_real <= '0;
      req_bus.sample_imag <= '0;
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_PACKETS_PER_SYMBOL;
      csr_write_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings, sample extremes
      send_sample(16'h0000, 16'h0000, 0);
      send_sample(16'h8000, 16'h7FFF, 0);
      send_sample(16'h7FFF, 16'h8000, 2);
      send_sample(16'hFFFF, 16'h0001, 0);
      wait_idle();

      // zero periods act as one; payload no longer than header; open packet closes at once
      write_reg(CSR_PACKETS_PER_SYMBOL, 9'h000);
      write_reg(CSR_SLOTS_PER_SUBFRAME, 9'h000);
      write_reg(CSR_RBS_PER_PACKET, 9'h000);
      write_reg(CSR_FIRST_BYTE, 9'h0FF);
      write_reg(CSR_SECTION_ID, 9'h1FF);
      write_reg(CSR_SYMBOL_INCREMENT, 9'h0FF);
      write_reg(CSR_START_PRB, 9'h0FF);
      write_reg(CSR_SPARE_INDEX, 9'h1FF);
      csr_write_en <= 1'b0;
      repeat (5) send_sample(pick_sample(), pick_sample(), pick_gap(1'b0));
      wait_idle();

      // widest settings, packet left open
      write_reg(CSR_PACKETS_PER_SYMBOL, 9'h1FF);
      write_reg(CSR_SLOTS_PER_SUBFRAME, 9'h1FF);
      write_reg(CSR_RBS_PER_PACKET, 9'h0FF);
      write_reg(CSR_FIRST_BYTE, 9'h000);
      write_reg(CSR_SECTION_ID, 9'h000);
      write_reg(CSR_SYMBOL_INCREMENT, 9'h100);
      write_reg(CSR_START_PRB, 9'h000);
      csr_write_en <= 1'b0;
      repeat (11) send_sample(pick_sample(), pick_sample(), pick_gap(1'b0));
      wait_idle();

      // shorter payload than already sent: next sample ends the packet
      write_reg(CSR_RBS_PER_PACKET, 9'h001);
      csr_write_en <= 1'b0;
      repeat (2) send_sample(pick_sample(), pick_sample(), 0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         if (phase == 0) begin
            // one header per sample so ids wrap; output held off while input keeps coming
            write_reg(CSR_PACKETS_PER_SYMBOL, 9'h001);
            write_reg(CSR_SLOTS_PER_SUBFRAME, 9'h001);
            write_reg(CSR_RBS_PER_PACKET, 9'h000);
            phase_len = 120;
            holds_asked++;
         end else begin
            if ($urandom_range(0, 1)) write_reg(CSR_PACKETS_PER_SYMBOL, pick_setting());
            if ($urandom_range(0, 1)) write_reg(CSR_SLOTS_PER_SUBFRAME, pick_setting());
            if ($urandom_range(0, 1)) write_reg(CSR_RBS_PER_PACKET, pick_setting());
            if ($urandom_range(0, 3) == 0)
               write_reg(CSR_FIRST_BYTE, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               write_reg(CSR_SECTION_ID, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               write_reg(CSR_SYMBOL_INCREMENT, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               write_reg(CSR_START_PRB, CSR_DATA_W'($urandom));
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
            phase_len = $urandom_range(5, 40);
         end
         csr_write_en <= 1'b0;
         calm = ($urandom_range(0, 3) == 0);
         repeat (phase_len) begin
            send_sample(pick_sample(), pick_sample(), pick_gap(calm));
            sent++;
         end
         phase++;
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
